>>> src/bped_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bped_pkg: shared types and constants for the bit-parallel edit distance unit
// Holds the transaction payload types, operation codes, controller state
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bped_pkg;

	localparam int SYM_W    = 8;
	localparam int DIST_W   = 16;
	localparam int OP_W     = 2;
	localparam int TBL_DEPTH = 1 << SYM_W;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Operation codes carried in the op field
	localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
	localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
	localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SYM_W-1:0] symbol;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              too_long;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;  // latch the incoming item, start table read
		logic exec;  // apply pattern or text update
		logic emit;  // load result register and clear all state
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

>>> src/bped_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bped_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bped_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> src/bped_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bped_ctrl: sequencing controller
// Takes one item, waits for the registered match-table read, then commands
// the update or the result emission.
// ----------------------------------------------------------------------------
module bped_ctrl
	import bped_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_ready,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold while a finish waits for the result register
				if (sts.op != OP_FINISH || sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.take   = item_valid;
			end
			ST_EXEC: begin
				cmd.exec = (sts.op == OP_PATTERN) || (sts.op == OP_TEXT);
				cmd.emit = (sts.op == OP_FINISH) && sts.out_free;
			end
			default: begin
				cmd        = '0;
				item_ready = 1'b0;
			end
		endcase
	end

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted while result register busy");

	a_single_action: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.emit) && !(cmd.take && (cmd.exec || cmd.emit)))
		else $error("conflicting datapath commands");

	a_exec_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.emit) |-> !item_ready)
		else $error("update issued while accepting a transaction");

endmodule
`default_nettype wire

>>> src/bped_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bped_dp: edit distance datapath
// Match-vector table with per-row valid bits, VP/VN vectors, pattern length,
// running distance, overflow flag and the result register.
// ----------------------------------------------------------------------------
module bped_dp
	import bped_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire item_t    item,
	input  wire ctl_cmd_t cmd,
	output ctl_sts_t      sts,
	output result_t       result,
	output logic          result_valid,
	input  wire logic     result_ready
);

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic [OP_W-1:0]    op_q;
	logic [SYM_W-1:0]   sym_q;
	logic [MAX_LEN-1:0] vp_q;
	logic [MAX_LEN-1:0] vn_q;
	logic [LEN_W-1:0]   len_q;
	logic [DIST_W-1:0]  dist_q;
	logic               ovf_q;
	logic [TBL_DEPTH-1:0] row_valid_q;
	result_t            result_q;
	logic               result_valid_q;

	logic [MAX_LEN-1:0] rd_data;
	logic [MAX_LEN-1:0] x;
	logic [MAX_LEN-1:0] pos_bit;
	logic [MAX_LEN-1:0] len_mask;
	logic [MAX_LEN-1:0] d0;
	logic [MAX_LEN-1:0] hp;
	logic [MAX_LEN-1:0] hn;
	logic [MAX_LEN-1:0] hps;
	logic [MAX_LEN-1:0] hns;
	logic [MAX_LEN:0]   hp_ext;
	logic [IDX_W-1:0]   top_idx;
	logic               has_room;
	logic               tbl_we;
	logic [DIST_W-1:0]  dist_inc;
	logic [DIST_W-1:0]  dist_dec;

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= item.op;
			sym_q <= item.symbol;
		end
	end

	// Match-vector table
	bped_ram #(
		.WIDTH (MAX_LEN),
		.DEPTH (TBL_DEPTH)
	) u_tbl (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (sym_q),
		.wr_data (x | pos_bit),
		.rd_en   (cmd.take),
		.rd_addr (item.symbol),
		.rd_data (rd_data)
	);

	// Rows not written since the last finish read as zero
	assign x        = row_valid_q[sym_q] ? rd_data : '0;
	assign has_room = (len_q < LEN_W'(MAX_LEN));
	assign pos_bit  = MAX_LEN'(1) << len_q[IDX_W-1:0];
	assign tbl_we   = cmd.exec && (op_q == OP_PATTERN) && has_room;

	// Myers step over the whole pattern vector
	assign d0     = (((x & vp_q) + vp_q) ^ vp_q) | x | vn_q;
	assign hp     = vn_q | ~(d0 | vp_q);
	assign hn     = d0 & vp_q;
	assign hp_ext = {hp, 1'b1};
	assign hps    = hp_ext[MAX_LEN-1:0];
	assign hns    = hn << 1;
	assign top_idx = IDX_W'(len_q - LEN_W'(1));

	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			len_mask[i] = (LEN_W'(i) < len_q);
		end
	end

	// Saturating distance moves
	assign dist_inc = (dist_q == DIST_MAX) ? dist_q : dist_q + DIST_W'(1);
	assign dist_dec = (dist_q == '0) ? dist_q : dist_q - DIST_W'(1);

	// Pattern/text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q        <= '0;
			vn_q        <= '0;
			len_q       <= '0;
			dist_q      <= '0;
			ovf_q       <= 1'b0;
			row_valid_q <= '0;
		end else if (cmd.emit) begin
			vp_q        <= '0;
			vn_q        <= '0;
			len_q       <= '0;
			dist_q      <= '0;
			ovf_q       <= 1'b0;
			row_valid_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == OP_PATTERN) begin
				if (has_room) begin
					vp_q               <= vp_q | pos_bit;
					vn_q               <= vn_q & ~pos_bit;
					len_q              <= len_q + LEN_W'(1);
					dist_q             <= dist_inc;
					row_valid_q[sym_q] <= 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (len_q == '0) begin
				// empty pattern: every text symbol is an insertion
				dist_q <= dist_inc;
			end else begin
				vp_q <= (hns | ~(d0 | hps)) & len_mask;
				vn_q <= (d0 & hps) & len_mask;
				if (hp[top_idx]) begin
					dist_q <= dist_inc;
				end else if (hn[top_idx]) begin
					dist_q <= dist_dec;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.distance <= dist_q;
			result_q.too_long <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign sts.op       = op_q;
	assign sts.out_free = !result_valid_q || result_ready;

	a_emit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("finish did not present a result");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("pattern length beyond capacity");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (len_q == '0) && (dist_q == '0) && (vp_q == '0) && !ovf_q)
		else $error("state not cleared after finish");

	a_vp_above_len: assert property (@(posedge clk) disable iff (!arst_n)
		((vp_q | vn_q) & ~len_mask) == '0)
		else $error("vector bits set above pattern length");

endmodule
`default_nettype wire

>>> src/bit_parallel_edit_distance_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bit_parallel_edit_distance_unit: streaming Levenshtein distance engine
// Loads a pattern byte by byte, streams text bytes through a bit-parallel
// vector update and reports the distance on a finish transaction.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      item_t   {op, symbol}
//   result    out        result_valid / result_ready  result_t {distance, too_long}
//
// Each transaction first reads the match-vector table row (registered RAM
// read), then applies the update.
// A finish waits in its update step while the result register is still held.
// Reset clears all control state and table row valid bits; no clearing pass.
// The result register frees the input side: new transactions are taken while
// a result waits for result_ready.
// ----------------------------------------------------------------------------
module bit_parallel_edit_distance_unit
	import bped_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	bped_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	bped_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
`default_nettype wire

>>> sim/edit_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_checker: transaction predictor and result comparator
// Watches the item and result channels of the edit distance unit. Keeps its
// own copy of the match table, the vertical delta vectors, the pattern length
// and the distance, and queues one expected result per accepted finish.
// Compares each accepted result with the oldest expectation.
// ----------------------------------------------------------------------------
module edit_distance_checker
	import bped_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	input  wire logic    item_ready,
	input  wire item_t   item,
	input  wire logic    result_valid,
	input  wire logic    result_ready,
	input  wire result_t result,
	output int           failures,
	output int           outstanding,
	output int           checked
);

	typedef logic [MAX_LEN-1:0] pvec_t;

	pvec_t             match_rows [TBL_DEPTH];
	pvec_t             vp_bits;
	pvec_t             vn_bits;
	int unsigned       pat_len;
	logic [DIST_W-1:0] run_dist;
	logic              overflow;
	result_t           expected_distances [$];
	int                fail_count = 0;
	int                check_count = 0;

	// Clear the predicted engine, as after reset or a finish
	function automatic void clear_engine();
		foreach (match_rows[i]) match_rows[i] = '0;
		vp_bits  = '0;
		vn_bits  = '0;
		pat_len  = 0;
		run_dist = '0;
		overflow = 1'b0;
	endfunction

	// Saturating increment of the running distance
	function automatic void distance_up();
		if (run_dist != DIST_MAX) begin
			run_dist = run_dist + 1'b1;
		end
	endfunction

	// Append one pattern byte, or flag the pattern as too long
	function automatic void load_pattern_byte(logic [SYM_W-1:0] sym);
		pvec_t pos;
		if (pat_len >= MAX_LEN) begin
			overflow = 1'b1;
		end else begin
			pos = pvec_t'(1) << pat_len;
			match_rows[sym] = match_rows[sym] | pos;
			vp_bits = vp_bits | pos;
			vn_bits = vn_bits & ~pos;
			pat_len = pat_len + 1;
			distance_up();
		end
	endfunction

	// Advance one text byte through the bit-parallel column update
	function automatic void advance_text_byte(logic [SYM_W-1:0] sym);
		pvec_t eq;
		pvec_t d0;
		pvec_t hp;
		pvec_t hn;
		pvec_t hp_in;
		pvec_t hn_in;
		pvec_t keep;
		if (pat_len == 0) begin
			distance_up();
		end else begin
			eq = match_rows[sym];
			d0 = (((eq & vp_bits) + vp_bits) ^ vp_bits) | eq | vn_bits;
			hp = vn_bits | ~(d0 | vp_bits);
			hn = d0 & vp_bits;
			// the horizontal delta at the top pattern position moves the distance
			if (hp[pat_len - 1]) begin
				distance_up();
			end else if (hn[pat_len - 1] && run_dist != '0) begin
				run_dist = run_dist - 1'b1;
			end
			hp_in = (hp << 1) | pvec_t'(1);
			hn_in = hn << 1;
			// hold bits above the pattern length at zero
			keep = pvec_t'('1) >> (MAX_LEN - pat_len);
			vp_bits = (hn_in | ~(d0 | hp_in)) & keep;
			vn_bits = d0 & hp_in & keep;
		end
	endfunction

	function automatic void report_failure(string msg);
		if (fail_count < 10) begin
			$display("%0t: %s", $realtime, msg);
		end
		fail_count++;
	endfunction

	// Check results first, then predict from the accepted transaction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			clear_engine();
			expected_distances.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_distances.size() == 0) begin
					report_failure($sformatf("unexpected result: distance %0d too_long %0b",
						result.distance, result.too_long));
				end else begin
					want = expected_distances.pop_front();
					check_count++;
					if (result.distance !== want.distance ||
							result.too_long !== want.too_long) begin
						report_failure($sformatf(
							"result mismatch: expected distance %0d too_long %0b, got %0d %0b",
							want.distance, want.too_long, result.distance, result.too_long));
					end
				end
			end
			if (item_valid && item_ready) begin
				case (item.op)
					OP_PATTERN: begin
						load_pattern_byte(item.symbol);
					end
					OP_TEXT: begin
						advance_text_byte(item.symbol);
					end
					OP_FINISH: begin
						fresh.distance = run_dist;
						fresh.too_long = overflow;
						expected_distances.push_back(fresh);
						clear_engine();
					end
					default: begin
						// unused op: drop, state unchanged
					end
				endcase
			end
		end
		failures    <= fail_count;
		outstanding <= expected_distances.size();
		checked     <= check_count;
	end

endmodule

>>> sim/bit_parallel_edit_distance_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_parallel_edit_distance_unit_test: top-level testbench
// Drives pattern, text and finish transactions into the edit distance unit
// with random sender gaps and receiver stalls. A directed opening covers
// extreme bytes, empty and over-length patterns, pattern after text and the
// unused op; random pattern/text/finish sequences over small and full
// alphabets follow. The checker beside the unit predicts and compares every
// result.
// ----------------------------------------------------------------------------
module bit_parallel_edit_distance_unit_test;
	import bped_pkg::*;

	localparam int MAX_LEN = 64;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int SETTLE = 8;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	logic    steady = 1'b0;
	int      failures;
	int      outstanding;
	int      checked;
	int      sent = 0;
	int      cycles = 0;

	bit_parallel_edit_distance_unit #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result
	);

	edit_distance_checker #(
		.MAX_LEN(MAX_LEN)
	) distance_check (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result,
		.failures,
		.outstanding,
		.checked
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random, except in steady stretches
	always @(posedge clk) begin
		result_ready <= steady || ($urandom_range(99) >= 35);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] base, int span);
		return base + SYM_W'($urandom_range(span - 1));
	endfunction

	// Present one transaction, with a random gap first, and hold until taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
		while (!steady && $urandom_range(99) < 35) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid  <= 1'b1;
		item.op     <= op;
		item.symbol <= sym;
		sent++;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_run(input logic [OP_W-1:0] op, input int count,
			input logic [SYM_W-1:0] base, input int span);
		for (int i = 0; i < count; i++) begin
			send_item(op, pick_symbol(base, span));
		end
	endtask

	// Hold the sender until every queued result has come back
	task automatic wait_for_drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int               rand_start;
		int               seq;
		int               span;
		int               plen;
		int               pick;
		logic [SYM_W-1:0] base;
		logic [OP_W-1:0]  op;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty engine: finish alone reports zero
		send_item(OP_FINISH, 8'h00);
		// empty pattern: text bytes count up, the unused op is dropped
		send_item(OP_TEXT, 8'h00);
		send_item(OP_UNUSED, 8'hFF);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_FINISH, 8'hFF);
		// exact match over the extreme byte values
		send_item(OP_PATTERN, 8'h00);
		send_item(OP_PATTERN, 8'hFF);
		send_item(OP_PATTERN, 8'h00);
		send_item(OP_TEXT, 8'h00);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_TEXT, 8'h00);
		send_item(OP_FINISH, 8'h5A);
		// pattern bytes arriving after text
		send_item(OP_PATTERN, 8'h41);
		send_item(OP_PATTERN, 8'h42);
		send_item(OP_TEXT, 8'h43);
		send_item(OP_PATTERN, 8'h44);
		send_item(OP_TEXT, 8'h41);
		send_item(OP_FINISH, 8'h00);
		// single pattern byte, no text
		send_item(OP_PATTERN, 8'hFF);
		send_item(OP_FINISH, 8'hFF);

		// over-length pattern: bytes past MAX_LEN only raise too_long
		send_run(OP_PATTERN, MAX_LEN + 3, 8'hFE, 4);
		send_run(OP_TEXT, 40, 8'hFE, 4);
		send_item(OP_FINISH, 8'h00);
		wait_for_drain();

		// random sequences, mostly well formed, some noise
		rand_start = sent;
		seq = 0;
		while (sent - rand_start < RANDOM_ITEMS) begin
			steady <= (seq >= 20 && seq < 32);
			if (seq == 40) begin
				wait_for_drain();
			end
			if ($urandom_range(99) < 80) begin
				case ($urandom_range(3))
					0: span = 2;
					1: span = 4;
					2: span = 26;
					default: span = 256;
				endcase
				base = SYM_W'($urandom_range(255));
				pick = $urandom_range(99);
				if (pick < 85) begin
					plen = $urandom_range(16, 1);
				end else if (pick < 95) begin
					plen = $urandom_range(MAX_LEN, 17);
				end else begin
					plen = $urandom_range(MAX_LEN + 6, MAX_LEN + 1);
				end
				send_run(OP_PATTERN, plen, base, span);
				send_run(OP_TEXT, $urandom_range(plen + 8, 0), base, span);
				send_item(OP_FINISH, pick_symbol(8'h00, 256));
			end else begin
				// noise: any op on any byte, state carries into the next sequence
				repeat ($urandom_range(8, 1)) begin
					op = OP_W'($urandom_range(3));
					send_item(op, SYM_W'($urandom_range(255)));
				end
			end
			seq++;
		end

		wait_for_drain();
		repeat (SETTLE) @(posedge clk);
		$display("checked %0d distance results over %0d transactions", checked, sent);
		$display("covered extreme bytes, over-length and late patterns, unused op, random runs");
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> sim.f
src/bped_pkg.sv
src/bped_ram.sv
src/bped_ctrl.sv
src/bped_dp.sv
src/bit_parallel_edit_distance_unit.sv
sim/edit_distance_checker.sv
sim/bit_parallel_edit_distance_unit_test.sv
